/* design/cau_pkg.sv */
// cau_pkg: shared widths, operation and status codes, and sideband type
// for the complex arithmetic unit. No dependencies.
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;          // fixed point word
    localparam int PW        = 2 * DW;      // product / magnitude width
    localparam int QW        = DW;          // quotient bits produced by the divider
    localparam int LANE_LAT  = QW + 2;      // prep stage, one stage per bit, rounding

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    // everything that travels beside the divider lanes
    typedef struct packed {
        op_t             op;
        logic            den_zero;
        logic            neg_re;
        logic            neg_im;
        logic [DW-1:0]   as_re;
        logic [DW-1:0]   as_im;
        logic            as_sat;
        logic [DW:0]     mul_mag_re;
        logic [DW:0]     mul_mag_im;
        logic            mul_ovf_re;
        logic            mul_ovf_im;
    } side_t;

endpackage

/* design/cau_div_lane.sv */
// cau_div_lane: pipelined restoring divider, one quotient bit per stage,
// rounds (num << FRAC_BITS) / den to nearest. Depends on cau_pkg.
module cau_div_lane (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [cau_pkg::PW-1:0]  num,
    input  logic [cau_pkg::PW-1:0]  den,
    output logic [cau_pkg::DW:0]    mag,
    output logic                    ovf
);
    import cau_pkg::*;

    localparam int SH = DW - FRAC_BITS;

    logic [PW-1:0] rem_reg [QW+1];
    logic [PW-1:0] den_reg [QW+1];
    logic [DW-1:0] lo_reg  [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];
    logic [DW:0]   mag_reg;
    logic          ovf_out_reg;
    logic [PW-1:0] num_sh;

    assign num_sh = num << FRAC_BITS;

    // quotient reaches 2^QW exactly when the top part of the dividend is not below den
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num >> SH;
            lo_reg[0]  <= num_sh[DW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num >> SH) >= den;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [PW:0] trial;
        logic        ge;
        assign trial = {rem_reg[i], lo_reg[i][DW-1]};
        assign ge    = trial >= {1'b0, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge ? PW'(trial - {1'b0, den_reg[i]}) : trial[PW-1:0];
                lo_reg[i+1]  <= {lo_reg[i][DW-2:0], 1'b0};
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= {q_reg[i][QW-2:0], ge};
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    // ties away from zero: round up when twice the remainder reaches den
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg     <= {1'b0, q_reg[QW]} +
                           (DW+1)'({rem_reg[QW], 1'b0} >= {1'b0, den_reg[QW]});
            ovf_out_reg <= ovf_reg[QW];
        end
    end

    assign mag = mag_reg;
    assign ovf = ovf_out_reg;

endmodule

/* design/complex_arithmetic_unit_top.sv */
// complex_arithmetic_unit_top: complex add, subtract, multiply and divide
// on signed Q16.16 operands. Depends on cau_pkg and cau_div_lane.
// All operations share one pipeline path, through the 32 divider bit stages.
// Throughput: one request per cycle while not stalled; the whole pipeline
// advances whenever the output register is empty or being taken.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
module complex_arithmetic_unit_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic signed [cau_pkg::DW-1:0] s_a_re,
    input  logic signed [cau_pkg::DW-1:0] s_a_im,
    input  logic signed [cau_pkg::DW-1:0] s_b_re,
    input  logic signed [cau_pkg::DW-1:0] s_b_im,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [cau_pkg::DW-1:0] m_result_re,
    output logic signed [cau_pkg::DW-1:0] m_result_im,
    output logic [1:0]                    m_status
);
    import cau_pkg::*;

    localparam logic [DW:0] MAX_POS = (DW+1)'((64'd1 << (DW-1)) - 64'd1);
    localparam logic [DW:0] MAX_NEG = (DW+1)'(64'd1 << (DW-1));

    logic en;

    // stage 1: input registers
    logic                 v1_reg;
    op_t                  op1_reg;
    logic signed [DW-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // stage 2: products and sums
    logic                 v2_reg;
    op_t                  op2_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbr_reg, pbi_reg;
    logic signed [DW:0]   as_re2_reg, as_im2_reg;

    // stage 3: combined parts
    logic                 v3_reg;
    op_t                  op3_reg;
    logic signed [PW:0]   re3_reg, im3_reg;
    logic [PW-1:0]        den3_reg;
    logic [DW-1:0]        as_re3_reg, as_im3_reg;
    logic                 as_sat3_reg;

    // stage 4: magnitudes
    logic                 v4_reg;
    op_t                  op4_reg;
    logic [PW-1:0]        mag_re4_reg, mag_im4_reg, den4_reg;
    logic                 neg_re4_reg, neg_im4_reg;
    logic [DW-1:0]        as_re4_reg, as_im4_reg;
    logic                 as_sat4_reg;

    // sideband beside the divider lanes
    logic                 vs_reg   [LANE_LAT];
    side_t                side_reg [LANE_LAT];
    side_t                side_next;

    logic [DW:0]          div_mag_re, div_mag_im;
    logic                 div_ovf_re, div_ovf_im;

    // output register
    logic                 m_valid_reg;
    logic [DW-1:0]        re_out_reg, im_out_reg;
    status_t              status_reg;
    logic [DW-1:0]        re_out_next, im_out_next;
    status_t              status_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= op_t'(s_operation);
            ar1_reg <= s_a_re;
            ai1_reg <= s_a_im;
            br1_reg <= s_b_re;
            bi1_reg <= s_b_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg <= op1_reg;
            prr_reg <= ar1_reg * br1_reg;
            pii_reg <= ai1_reg * bi1_reg;
            pri_reg <= ar1_reg * bi1_reg;
            pir_reg <= ai1_reg * br1_reg;
            pbr_reg <= br1_reg * br1_reg;
            pbi_reg <= bi1_reg * bi1_reg;
            if (op1_reg == OP_SUB) begin
                as_re2_reg <= (DW+1)'(ar1_reg) - (DW+1)'(br1_reg);
                as_im2_reg <= (DW+1)'(ai1_reg) - (DW+1)'(bi1_reg);
            end else begin
                as_re2_reg <= (DW+1)'(ar1_reg) + (DW+1)'(br1_reg);
                as_im2_reg <= (DW+1)'(ai1_reg) + (DW+1)'(bi1_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op3_reg  <= op2_reg;
            den3_reg <= pbr_reg + pbi_reg;
            if (op2_reg == OP_DIV) begin
                re3_reg <= (PW+1)'(prr_reg) + (PW+1)'(pii_reg);
                im3_reg <= (PW+1)'(pir_reg) - (PW+1)'(pri_reg);
            end else begin
                re3_reg <= (PW+1)'(prr_reg) - (PW+1)'(pii_reg);
                im3_reg <= (PW+1)'(pri_reg) + (PW+1)'(pir_reg);
            end
            // a sum overflows when its two top bits differ
            as_re3_reg  <= (as_re2_reg[DW] != as_re2_reg[DW-1]) ?
                           (as_re2_reg[DW] ? MAX_NEG[DW-1:0] : MAX_POS[DW-1:0]) :
                           as_re2_reg[DW-1:0];
            as_im3_reg  <= (as_im2_reg[DW] != as_im2_reg[DW-1]) ?
                           (as_im2_reg[DW] ? MAX_NEG[DW-1:0] : MAX_POS[DW-1:0]) :
                           as_im2_reg[DW-1:0];
            as_sat3_reg <= (as_re2_reg[DW] != as_re2_reg[DW-1]) ||
                           (as_im2_reg[DW] != as_im2_reg[DW-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op4_reg     <= op3_reg;
            den4_reg    <= den3_reg;
            neg_re4_reg <= re3_reg[PW];
            neg_im4_reg <= im3_reg[PW];
            mag_re4_reg <= re3_reg[PW] ? PW'(-re3_reg) : re3_reg[PW-1:0];
            mag_im4_reg <= im3_reg[PW] ? PW'(-im3_reg) : im3_reg[PW-1:0];
            as_re4_reg  <= as_re3_reg;
            as_im4_reg  <= as_im3_reg;
            as_sat4_reg <= as_sat3_reg;
        end
    end

    cau_div_lane u_div_re (
        .aclk (aclk),
        .en   (en),
        .num  (mag_re4_reg),
        .den  (den4_reg),
        .mag  (div_mag_re),
        .ovf  (div_ovf_re)
    );

    cau_div_lane u_div_im (
        .aclk (aclk),
        .en   (en),
        .num  (mag_im4_reg),
        .den  (den4_reg),
        .mag  (div_mag_im),
        .ovf  (div_ovf_im)
    );

    // product rounding: drop the fraction, add its top bit
    always_comb begin
        logic [PW-1:0] mq_re, mq_im;
        mq_re = mag_re4_reg >> FRAC_BITS;
        mq_im = mag_im4_reg >> FRAC_BITS;
        side_next.op         = op4_reg;
        side_next.den_zero   = (den4_reg == '0);
        side_next.neg_re     = neg_re4_reg;
        side_next.neg_im     = neg_im4_reg;
        side_next.as_re      = as_re4_reg;
        side_next.as_im      = as_im4_reg;
        side_next.as_sat     = as_sat4_reg;
        side_next.mul_mag_re = {1'b0, mq_re[DW-1:0]} + (DW+1)'(mag_re4_reg[FRAC_BITS-1]);
        side_next.mul_mag_im = {1'b0, mq_im[DW-1:0]} + (DW+1)'(mag_im4_reg[FRAC_BITS-1]);
        side_next.mul_ovf_re = (mq_re >> DW) != '0;
        side_next.mul_ovf_im = (mq_im >> DW) != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANE_LAT; i++) vs_reg[i] <= 1'b0;
        end else if (en) begin
            vs_reg[0] <= v4_reg;
            for (int i = 1; i < LANE_LAT; i++) vs_reg[i] <= vs_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < LANE_LAT; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    // final selection and saturation
    always_comb begin
        side_t         sd;
        logic [DW:0]   mre, mim;
        logic          ore, oim, sre, sim;
        logic [DW-1:0] rre, rim;
        sd  = side_reg[LANE_LAT-1];
        mre = (sd.op == OP_DIV) ? div_mag_re : sd.mul_mag_re;
        mim = (sd.op == OP_DIV) ? div_mag_im : sd.mul_mag_im;
        ore = (sd.op == OP_DIV) ? div_ovf_re : sd.mul_ovf_re;
        oim = (sd.op == OP_DIV) ? div_ovf_im : sd.mul_ovf_im;
        sre = ore || (mre > (sd.neg_re ? MAX_NEG : MAX_POS));
        sim = oim || (mim > (sd.neg_im ? MAX_NEG : MAX_POS));
        rre = sre ? (sd.neg_re ? MAX_NEG[DW-1:0] : MAX_POS[DW-1:0]) :
              (sd.neg_re ? DW'(-mre) : mre[DW-1:0]);
        rim = sim ? (sd.neg_im ? MAX_NEG[DW-1:0] : MAX_POS[DW-1:0]) :
              (sd.neg_im ? DW'(-mim) : mim[DW-1:0]);
        case (sd.op)
            OP_ADD, OP_SUB: begin
                re_out_next = sd.as_re;
                im_out_next = sd.as_im;
                status_next = sd.as_sat ? ST_SAT : ST_OK;
            end
            OP_MUL: begin
                re_out_next = rre;
                im_out_next = rim;
                status_next = (sre || sim) ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (sd.den_zero) begin
                    re_out_next = '0;
                    im_out_next = '0;
                    status_next = ST_DIV0;
                end else begin
                    re_out_next = rre;
                    im_out_next = rim;
                    status_next = (sre || sim) ? ST_SAT : ST_OK;
                end
            end
            default: begin
                re_out_next = '0;
                im_out_next = '0;
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vs_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_out_reg <= re_out_next;
            im_out_reg <= im_out_next;
            status_reg <= status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_result_re = re_out_reg;
    assign m_result_im = im_out_reg;
    assign m_status    = status_reg;

endmodule

/* design/cau_checker.sv */
// cau_checker: port-level checks for complex_arithmetic_unit_top, bound to it
// below. Depends on cau_pkg.
module cau_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [cau_pkg::DW-1:0] m_result_re,
    input logic signed [cau_pkg::DW-1:0] m_result_im,
    input logic [1:0]                    m_status
);
    import cau_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_re) &&
        $stable(m_result_im) && $stable(m_status))
        else $error("result changed while stalled");

    // input stalls only behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_DIV0 || m_status == ST_SAT)
        else $error("undefined status code");

    a_div0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_DIV0 |-> m_result_re == '0 && m_result_im == '0)
        else $error("divide by zero with nonzero result");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_result_re (m_result_re),
    .m_result_im (m_result_im),
    .m_status    (m_status)
);
